// ===== hdl/swe_pkg.sv =====
// Shared types, codes and default sizes of the search window estimator.
`timescale 1ns / 1ps
package swe_pkg;

    localparam int MAX_POINTS_DEF  = 65535;
    localparam int COORD_WIDTH_DEF = 20;

    // Coordinates carry this many fraction bits (Q11.8 at the default width).
    localparam int FRAC_BITS = 8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    localparam logic [2:0] MUL_SQX = 3'd0;
    localparam logic [2:0] MUL_SQY = 3'd1;
    localparam logic [2:0] MUL_DEN = 3'd2;
    localparam logic [2:0] MUL_PN  = 3'd3;
    localparam logic [2:0] MUL_CP  = 3'd4;

    typedef struct packed {
        logic       acc;
        logic       ext;
        logic       mul_go;
        logic [2:0] mul_op;
        logic       sqrt_go;
        logic       div_go;
        logic       axis;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
    } t_stat;

endpackage

// ===== hdl/search_window_estimator_top.sv =====
// Top level of the search window estimator: controller and datapath.
`timescale 1ns / 1ps
// Points of the current cloud (mode 0) and the previous cloud (mode 1) are
// taken one per cycle: a transfer happens at each rising edge where start is
// high and busy is low. Every point updates its cloud's count, x and y sums
// and bounding box; a point that arrives while its cloud already holds
// MAX_POINTS points is dropped and marks overflow. The point flagged
// last_point closes both clouds: busy then rises and the block works out the
// rounded centroid difference (previous minus current), the larger extent of
// the two boxes on each axis, and half their diagonal rounded up to whole
// metres, W. The result transfer is a single cycle with o_valid high,
// carrying [d - W, d + W] for x and y, saturated to the coordinate range,
// and a status code (0 ok, 1 a cloud was empty, 2 overflow). The receiver
// cannot hold a result off, so it must take it in that cycle. After the
// last point busy stays high for the closing sequence, run on one shared
// shift-add multiplier (seven products of MB_W multiplier bits each, MB_W
// being the larger of the count width and COORD_WIDTH), a two-bit-per-cycle
// square root and a one-bit-per-cycle divider run twice. Empty clouds skip
// the arithmetic and go straight from the extent step to the output step.
// The result appears as busy falls, and the state is back at its reset
// values by then.
module search_window_estimator_top
    import swe_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_last_point,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_x_low,
    output logic signed [COORD_WIDTH-1:0] o_x_high,
    output logic signed [COORD_WIDTH-1:0] o_y_low,
    output logic signed [COORD_WIDTH-1:0] o_y_high,
    output logic [1:0]                    o_status
);

    t_cmd  cmd;
    t_stat stat;

    // The controller sees start only while idle, so a raised start during
    // the closing sequence is ignored, as the handshake requires.
    swe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_point (i_last_point),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    swe_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_mode    (i_mode),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .o_stat    (stat),
        .o_x_low   (o_x_low),
        .o_x_high  (o_x_high),
        .o_y_low   (o_y_low),
        .o_y_high  (o_y_high),
        .o_status  (o_status),
        .o_valid   (o_valid)
    );

endmodule

// ===== hdl/swe_ctrl.sv =====
// Sequencer of the search window estimator: accumulation, then the closing computation.
`timescale 1ns / 1ps
module swe_ctrl
    import swe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_last_point,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXT  = 4'd1;
    localparam logic [3:0] S_SQX  = 4'd2;
    localparam logic [3:0] S_SQY  = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_DEN  = 4'd5;
    localparam logic [3:0] S_PN0  = 4'd6;
    localparam logic [3:0] S_CP0  = 4'd7;
    localparam logic [3:0] S_DIV0 = 4'd8;
    localparam logic [3:0] S_PN1  = 4'd9;
    localparam logic [3:0] S_CP1  = 4'd10;
    localparam logic [3:0] S_DIV1 = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_launched, n_launched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_launched = r_launched;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.acc = 1'b1;
                    if (i_last_point) begin
                        n_state = S_EXT;
                    end
                end
            end
            S_EXT: begin
                o_cmd.ext = 1'b1;
                n_state   = i_stat.empty ? S_OUT : S_SQX;
            end
            S_SQX, S_SQY, S_DEN, S_PN0, S_CP0, S_PN1, S_CP1: begin
                case (r_state)
                    S_SQX:        o_cmd.mul_op = MUL_SQX;
                    S_SQY:        o_cmd.mul_op = MUL_SQY;
                    S_DEN:        o_cmd.mul_op = MUL_DEN;
                    S_PN0, S_PN1: o_cmd.mul_op = MUL_PN;
                    default:      o_cmd.mul_op = MUL_CP;
                endcase
                o_cmd.axis = (r_state == S_PN1) || (r_state == S_CP1);
                if (!r_launched) begin
                    o_cmd.mul_go = 1'b1;
                    n_launched   = 1'b1;
                end else if (i_stat.mul_done) begin
                    n_launched = 1'b0;
                    case (r_state)
                        S_SQX:   n_state = S_SQY;
                        S_SQY:   n_state = S_SQRT;
                        S_DEN:   n_state = S_PN0;
                        S_PN0:   n_state = S_CP0;
                        S_CP0:   n_state = S_DIV0;
                        S_PN1:   n_state = S_CP1;
                        default: n_state = S_DIV1;
                    endcase
                end
            end
            S_SQRT: begin
                if (!r_launched) begin
                    o_cmd.sqrt_go = 1'b1;
                    n_launched    = 1'b1;
                end else if (i_stat.sqrt_done) begin
                    n_launched = 1'b0;
                    n_state    = S_DEN;
                end
            end
            S_DIV0, S_DIV1: begin
                o_cmd.axis = (r_state == S_DIV1);
                if (!r_launched) begin
                    o_cmd.div_go = 1'b1;
                    n_launched   = 1'b1;
                end else if (i_stat.div_done) begin
                    n_launched = 1'b0;
                    n_state    = (r_state == S_DIV0) ? S_PN1 : S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state    = S_IDLE;
                n_launched = 1'b0;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/swe_dp.sv =====
// Datapath of the search window estimator: accumulators and the shared serial arithmetic.
`timescale 1ns / 1ps
module swe_dp
    import swe_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic                          i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    output t_stat                         o_stat,
    output logic signed [COORD_WIDTH-1:0] o_x_low,
    output logic signed [COORD_WIDTH-1:0] o_x_high,
    output logic signed [COORD_WIDTH-1:0] o_y_low,
    output logic signed [COORD_WIDTH-1:0] o_y_high,
    output logic [1:0]                    o_status,
    output logic                          o_valid
);

    localparam int CW     = COORD_WIDTH;
    localparam int CW1    = CW + 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = CW + CNT_W;
    localparam int MB_W   = (CNT_W > CW) ? CNT_W : CW;
    localparam int MBC_W  = $clog2(MB_W);
    localparam int PW     = SUM_W + MB_W;
    localparam int NUM_W  = PW + 1;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int DVD_W  = NUM_W + 1;
    localparam int DVC_W  = $clog2(DVD_W);
    localparam int D_W    = CW + 2;
    localparam int SW     = 2 * CW + 1;
    localparam int SQ_W   = SW + (SW % 2);
    localparam int SQ_N   = SQ_W / 2;
    localparam int SQC_W  = $clog2(SQ_N);
    localparam int SR_W   = CW + 3;
    localparam int RT_W   = CW + 1;
    localparam int W_W    = CW + 1;
    localparam int B_W    = CW + 3;
    localparam int M_SH   = FRAC_BITS + 1;

    localparam logic [CNT_W-1:0]       CNT_FULL  = CNT_W'(MAX_POINTS);
    localparam logic signed [CW-1:0]   COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0]   COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [B_W-1:0]  BND_MAX   = B_W'(COORD_MAX);
    localparam logic signed [B_W-1:0]  BND_MIN   = B_W'(COORD_MIN);
    localparam logic [RT_W:0]          RND_UP    = (RT_W+1)'((1 << M_SH) - 1);

    // Per cloud accumulators; index 0 is x, 1 is y.
    logic [CNT_W-1:0]        r_cnt_c, r_cnt_p;
    logic signed [SUM_W-1:0] r_sum_c [2];
    logic signed [SUM_W-1:0] r_sum_p [2];
    logic signed [CW-1:0]    r_min_c [2];
    logic signed [CW-1:0]    r_max_c [2];
    logic signed [CW-1:0]    r_min_p [2];
    logic signed [CW-1:0]    r_max_p [2];
    logic                    r_ovf;
    logic signed [CW-1:0]    px [2];

    assign px[0] = i_point_x;
    assign px[1] = i_point_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_cnt_c <= '0;
            r_cnt_p <= '0;
            r_ovf   <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                r_sum_c[k] <= '0;
                r_sum_p[k] <= '0;
                r_min_c[k] <= COORD_MAX;
                r_min_p[k] <= COORD_MAX;
                r_max_c[k] <= COORD_MIN;
                r_max_p[k] <= COORD_MIN;
            end
        end else if (i_cmd.acc) begin
            if (!i_mode) begin
                if (r_cnt_c == CNT_FULL) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt_c <= r_cnt_c + 1'b1;
                    for (int k = 0; k < 2; k++) begin
                        r_sum_c[k] <= r_sum_c[k] + SUM_W'(px[k]);
                        if (px[k] < r_min_c[k]) r_min_c[k] <= px[k];
                        if (px[k] > r_max_c[k]) r_max_c[k] <= px[k];
                    end
                end
            end else begin
                if (r_cnt_p == CNT_FULL) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt_p <= r_cnt_p + 1'b1;
                    for (int k = 0; k < 2; k++) begin
                        r_sum_p[k] <= r_sum_p[k] + SUM_W'(px[k]);
                        if (px[k] < r_min_p[k]) r_min_p[k] <= px[k];
                        if (px[k] > r_max_p[k]) r_max_p[k] <= px[k];
                    end
                end
            end
        end
    end

    logic empty;
    assign empty = (r_cnt_c == '0) || (r_cnt_p == '0);

    // Larger bounding extent of the two clouds on each axis.
    logic [CW-1:0]        r_ext [2];
    logic signed [CW:0]   ec [2];
    logic signed [CW:0]   ep [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            ec[k] = CW1'(r_max_c[k]) - CW1'(r_min_c[k]);
            ep[k] = CW1'(r_max_p[k]) - CW1'(r_min_p[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ext) begin
            for (int k = 0; k < 2; k++) begin
                r_ext[k] <= (ec[k] > ep[k]) ? ec[k][CW-1:0] : ep[k][CW-1:0];
            end
        end
    end

    // Shift-add multiplier, one multiplier bit per cycle.
    logic signed [PW-1:0] r_mul_a, r_mul_acc, n_mul_acc, ld_a;
    logic [MB_W-1:0]      r_mul_b, ld_b;
    logic [MBC_W-1:0]     r_mul_cnt;
    logic                 r_mul_run, r_mul_done, mul_last;
    logic [2:0]           r_mul_op;
    logic [SW-1:0]        r_s;
    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0]     r_den;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_SQX: begin
                ld_a = $signed(PW'(r_ext[0]));
                ld_b = MB_W'(r_ext[0]);
            end
            MUL_SQY: begin
                ld_a = $signed(PW'(r_ext[1]));
                ld_b = MB_W'(r_ext[1]);
            end
            MUL_DEN: begin
                ld_a = $signed(PW'(r_cnt_c));
                ld_b = MB_W'(r_cnt_p);
            end
            MUL_PN: begin
                ld_a = PW'(r_sum_p[i_cmd.axis]);
                ld_b = MB_W'(r_cnt_c);
            end
            MUL_CP: begin
                ld_a = PW'(r_sum_c[i_cmd.axis]);
                ld_b = MB_W'(r_cnt_p);
            end
            default: begin
                ld_a = '0;
                ld_b = '0;
            end
        endcase
    end

    assign n_mul_acc = r_mul_acc + (r_mul_b[0] ? r_mul_a : '0);
    assign mul_last  = (r_mul_cnt == MBC_W'(MB_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_run  <= 1'b0;
            r_mul_done <= 1'b0;
        end else begin
            r_mul_done <= r_mul_run && mul_last;
            if (i_cmd.mul_go) begin
                r_mul_run <= 1'b1;
            end else if (r_mul_run && mul_last) begin
                r_mul_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_mul_a   <= ld_a;
            r_mul_b   <= ld_b;
            r_mul_acc <= '0;
            r_mul_cnt <= '0;
            r_mul_op  <= i_cmd.mul_op;
        end else if (r_mul_run) begin
            r_mul_a   <= r_mul_a <<< 1;
            r_mul_b   <= r_mul_b >> 1;
            r_mul_acc <= n_mul_acc;
            r_mul_cnt <= r_mul_cnt + 1'b1;
            if (mul_last) begin
                case (r_mul_op)
                    MUL_SQX: r_s   <= SW'(n_mul_acc);
                    MUL_SQY: r_s   <= r_s + SW'(n_mul_acc);
                    MUL_DEN: r_den <= DEN_W'(n_mul_acc);
                    MUL_PN:  r_num <= NUM_W'(n_mul_acc);
                    MUL_CP:  r_num <= r_num - NUM_W'(n_mul_acc);
                    default: r_num <= r_num;
                endcase
            end
        end
    end

    // Digit-by-digit square root, two radicand bits per cycle, then the
    // half diagonal rounded up to whole metres.
    logic [SQ_W-1:0]  r_sq_s;
    logic [SR_W-1:0]  r_sq_rem, sq_r2, sq_trial, n_sq_rem;
    logic [RT_W-1:0]  r_sq_root, n_sq_root;
    logic [SQC_W-1:0] r_sq_cnt;
    logic             r_sq_run, r_sq_done, sq_last, sq_ge;
    logic [W_W-1:0]   r_w, n_w;
    logic [RT_W:0]    m_ceil, m_floor1;

    assign sq_r2     = {r_sq_rem[SR_W-3:0], r_sq_s[SQ_W-1 -: 2]};
    assign sq_trial  = SR_W'({r_sq_root, 2'b01});
    assign sq_ge     = (sq_r2 >= sq_trial);
    assign n_sq_rem  = sq_ge ? (sq_r2 - sq_trial) : sq_r2;
    assign n_sq_root = {r_sq_root[RT_W-2:0], sq_ge};
    assign sq_last   = (r_sq_cnt == SQC_W'(SQ_N - 1));
    assign m_ceil    = ((RT_W+1)'(n_sq_root) + RND_UP) >> M_SH;
    assign m_floor1  = (RT_W+1)'(n_sq_root >> M_SH) + 1'b1;
    assign n_w       = (n_sq_rem == '0) ? W_W'(m_ceil << FRAC_BITS)
                                        : W_W'(m_floor1 << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_run  <= 1'b0;
            r_sq_done <= 1'b0;
        end else begin
            r_sq_done <= r_sq_run && sq_last;
            if (i_cmd.sqrt_go) begin
                r_sq_run <= 1'b1;
            end else if (r_sq_run && sq_last) begin
                r_sq_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_go) begin
            r_sq_s    <= SQ_W'(r_s);
            r_sq_rem  <= '0;
            r_sq_root <= '0;
            r_sq_cnt  <= '0;
        end else if (r_sq_run) begin
            r_sq_s    <= r_sq_s << 2;
            r_sq_rem  <= n_sq_rem;
            r_sq_root <= n_sq_root;
            r_sq_cnt  <= r_sq_cnt + 1'b1;
            if (sq_last) begin
                r_w <= n_w;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle. Half the divisor is
    // added to the magnitude first, so the quotient is rounded to nearest
    // with ties away from zero.
    logic [DVD_W-1:0]     r_div_dvd;
    logic [DEN_W-1:0]     r_div_rem, n_div_rem;
    logic [DEN_W:0]       div_trial;
    logic [D_W-1:0]       r_div_q, div_qf;
    logic [DVC_W-1:0]     r_div_cnt;
    logic                 r_div_run, r_div_done, r_div_neg, r_div_axis, div_last, div_ge;
    logic [NUM_W-1:0]     num_mag;
    logic signed [D_W-1:0] r_d [2];

    assign num_mag   = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign div_trial = {r_div_rem, r_div_dvd[DVD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_den});
    assign n_div_rem = div_ge ? DEN_W'(div_trial - {1'b0, r_den}) : div_trial[DEN_W-1:0];
    assign div_qf    = {r_div_q[D_W-2:0], div_ge};
    assign div_last  = (r_div_cnt == DVC_W'(DVD_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run  <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_div_done <= r_div_run && div_last;
            if (i_cmd.div_go) begin
                r_div_run <= 1'b1;
            end else if (r_div_run && div_last) begin
                r_div_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_div_dvd  <= DVD_W'(num_mag) + DVD_W'(r_den >> 1);
            r_div_rem  <= '0;
            r_div_q    <= '0;
            r_div_cnt  <= '0;
            r_div_neg  <= r_num[NUM_W-1];
            r_div_axis <= i_cmd.axis;
        end else if (r_div_run) begin
            r_div_dvd <= r_div_dvd << 1;
            r_div_rem <= n_div_rem;
            r_div_q   <= div_qf;
            r_div_cnt <= r_div_cnt + 1'b1;
            if (div_last) begin
                r_d[r_div_axis] <= r_div_neg ? -$signed(div_qf) : $signed(div_qf);
            end
        end
    end

    // Window bounds, saturated to the coordinate range; zero when a cloud is empty.
    logic signed [B_W-1:0] bnd_w;
    logic signed [B_W-1:0] bnd_raw [4];
    logic signed [CW-1:0]  bnd_sat [4];
    logic [1:0]            n_status;

    always_comb begin
        bnd_w      = $signed(B_W'(r_w));
        bnd_raw[0] = B_W'(r_d[0]) - bnd_w;
        bnd_raw[1] = B_W'(r_d[0]) + bnd_w;
        bnd_raw[2] = B_W'(r_d[1]) - bnd_w;
        bnd_raw[3] = B_W'(r_d[1]) + bnd_w;
        for (int k = 0; k < 4; k++) begin
            if (empty) begin
                bnd_sat[k] = '0;
            end else if (bnd_raw[k] > BND_MAX) begin
                bnd_sat[k] = COORD_MAX;
            end else if (bnd_raw[k] < BND_MIN) begin
                bnd_sat[k] = COORD_MIN;
            end else begin
                bnd_sat[k] = bnd_raw[k][CW-1:0];
            end
        end
        if (empty) begin
            n_status = ST_EMPTY;
        end else if (r_ovf) begin
            n_status = ST_OVF;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_x_low  <= bnd_sat[0];
            o_x_high <= bnd_sat[1];
            o_y_low  <= bnd_sat[2];
            o_y_high <= bnd_sat[3];
            o_status <= n_status;
        end
    end

    assign o_stat.empty     = empty;
    assign o_stat.mul_done  = r_mul_done;
    assign o_stat.sqrt_done = r_sq_done;
    assign o_stat.div_done  = r_div_done;

endmodule
